>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: a implies b");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: a implies b next cycle");
`endif

>>> rtl/dcbc_pkg.sv
`timescale 1ns / 1ps
package dcbc_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_RUN,
    ST_WAIT
  } state_t;

  localparam logic FUNC_KEY   = 1'b0;
  localparam logic FUNC_BLOCK = 1'b1;

  localparam logic [1:0] CFG_DECRYPT = 2'd0;
  localparam logic [1:0] CFG_ROUNDS  = 2'd1;
  localparam logic [1:0] CFG_IV      = 2'd2;

  localparam int unsigned BLOCK_W = 64;
  localparam int unsigned HALF_W  = 32;
  localparam int unsigned KEY_W   = 48;

  localparam byte unsigned IP_TAB [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

  localparam byte unsigned FP_TAB [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

  localparam byte unsigned E_TAB [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};

  localparam byte unsigned P_TAB [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};

  localparam logic [3:0] SBOX [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  // bit 1 is the MSB throughout
  function automatic logic [63:0] ip_perm(input logic [63:0] s);
    logic [63:0] r;
    for (int k = 0; k < 64; k++) r[63-k] = s[64-int'(IP_TAB[k])];
    return r;
  endfunction

  function automatic logic [63:0] fp_perm(input logic [63:0] s);
    logic [63:0] r;
    for (int k = 0; k < 64; k++) r[63-k] = s[64-int'(FP_TAB[k])];
    return r;
  endfunction

  function automatic logic [47:0] e_perm(input logic [31:0] s);
    logic [47:0] r;
    for (int k = 0; k < 48; k++) r[47-k] = s[32-int'(E_TAB[k])];
    return r;
  endfunction

  function automatic logic [31:0] p_perm(input logic [31:0] s);
    logic [31:0] r;
    for (int k = 0; k < 32; k++) r[31-k] = s[32-int'(P_TAB[k])];
    return r;
  endfunction

endpackage

>>> rtl/dcbc_round.sv
`timescale 1ns / 1ps
module dcbc_round (
  input  logic [31:0] half,
  input  logic [47:0] round_key,
  output logic [31:0] f_out
);

  logic [47:0] x;
  logic [31:0] s;
  logic [5:0]  chunk;

  always_comb begin
    x = dcbc_pkg::e_perm(half) ^ round_key;
    s = '0;
    chunk = '0;
    for (int j = 0; j < 8; j++) begin
      chunk = x[47-6*j -: 6];
      s[31-4*j -: 4] = dcbc_pkg::SBOX[j][{chunk[5], chunk[0], chunk[4:1]}];
    end
    f_out = dcbc_pkg::p_perm(s);
  end

endmodule

>>> rtl/des_cbc_block_cipher_top.sv
`timescale 1ns / 1ps
// A block passes through a prime state for the round key memory read, then one Feistel
// round per cycle in the run state (r = rounds, 0..MAX_ROUNDS), then a wait state that
// registers the result; with no rounds it goes straight to the wait state. No new block
// is accepted until the result has left the wait state; output stalls hold it there.
// A key load is written to the key memory on acceptance and leaves the block idle.
// Reset (rst, synchronous): chain value and IV cleared, encrypt, 16 rounds;
// the key memory is not cleared.
`include "assert_macros.svh"
module des_cbc_block_cipher_top #(
  parameter int MAX_ROUNDS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [3:0]  key_slot,
  input  logic [47:0] key_value,
  input  logic [63:0] data_block,
  input  logic        first_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_block
);

  localparam int AW = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;

  dcbc_pkg::state_t state, state_next;

  logic        decrypt_mode;
  logic [4:0]  round_count;
  logic [63:0] init_vector;
  logic [63:0] chain_value;

  logic [47:0] key_mem [MAX_ROUNDS];
  logic [47:0] rd_key;
  logic [AW-1:0] rd_addr;

  logic [4:0]    rounds;
  logic          dec;
  logic [AW-1:0] idx;
  logic [31:0]   left, right;
  logic [63:0]   cv_used, data_held, res;

  logic        in_acc, out_acc, blk_acc, key_acc, last_round, slot_ok;
  logic [4:0]  r_sat, sel_round, kidx;
  logic [63:0] x_in, p_in;
  logic [31:0] f_val, nl;
  logic [63:0] fin;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign blk_acc   = in_acc && (func == dcbc_pkg::FUNC_BLOCK);
  assign key_acc   = in_acc && (func == dcbc_pkg::FUNC_KEY);
  assign slot_ok   = ({1'b0, key_slot} < 5'(MAX_ROUNDS));
  assign r_sat     = (round_count > 5'(MAX_ROUNDS)) ? 5'(MAX_ROUNDS) : round_count;
  assign last_round = (5'(idx) + 5'd1 == rounds);

  always_comb begin
    x_in = decrypt_mode ? data_block
         : data_block ^ (first_block ? init_vector : chain_value);
    p_in = dcbc_pkg::ip_perm(x_in);
    sel_round = (state == dcbc_pkg::ST_PRIME) ? 5'd0 : 5'(idx) + 5'd1;
    kidx = dec ? (rounds - 5'd1 - sel_round) : sel_round;
    rd_addr = kidx[AW-1:0];
    nl = left ^ f_val;
    fin = dcbc_pkg::fp_perm({nl, right});
  end

  dcbc_round u_round (
    .half      (right),
    .round_key (rd_key),
    .f_out     (f_val)
  );

  always_ff @(posedge clk) begin
    if (key_acc && slot_ok) begin
      key_mem[key_slot[AW-1:0]] <= key_value;
    end
    rd_key <= key_mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      dcbc_pkg::ST_IDLE: begin
        if (blk_acc) state_next = (r_sat == 5'd0) ? dcbc_pkg::ST_WAIT : dcbc_pkg::ST_PRIME;
      end
      dcbc_pkg::ST_PRIME: state_next = dcbc_pkg::ST_RUN;
      dcbc_pkg::ST_RUN: begin
        if (last_round) state_next = dcbc_pkg::ST_WAIT;
      end
      dcbc_pkg::ST_WAIT: begin
        if (!out_valid || !out_stall) state_next = dcbc_pkg::ST_IDLE;
      end
      default: state_next = dcbc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != dcbc_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= dcbc_pkg::ST_IDLE;
      decrypt_mode <= 1'b0;
      round_count  <= 5'd16;
      init_vector  <= '0;
      chain_value  <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dcbc_pkg::CFG_DECRYPT: decrypt_mode <= cfg_data[0];
          dcbc_pkg::CFG_ROUNDS:  round_count  <= cfg_data[4:0];
          dcbc_pkg::CFG_IV:      init_vector  <= cfg_data;
          default: ;
        endcase
      end
      if (blk_acc && r_sat == 5'd0) begin
        chain_value <= decrypt_mode ? data_block : x_in;
      end else if (state == dcbc_pkg::ST_RUN && last_round) begin
        chain_value <= dec ? data_held : fin;
      end
      if (state == dcbc_pkg::ST_WAIT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_acc) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (blk_acc) begin
      rounds    <= r_sat;
      dec       <= decrypt_mode;
      cv_used   <= first_block ? init_vector : chain_value;
      data_held <= data_block;
      left      <= p_in[63:32];
      right     <= p_in[31:0];
      idx       <= '0;
      res       <= decrypt_mode ? data_block ^ (first_block ? init_vector : chain_value)
                 : x_in;
    end else if (state == dcbc_pkg::ST_RUN) begin
      idx <= idx + AW'(1);
      if (last_round) begin
        res <= dec ? fin ^ cv_used : fin;
      end else begin
        left  <= right;
        right <= nl;
      end
    end
    if (state == dcbc_pkg::ST_WAIT && (!out_valid || !out_stall)) begin
      out_block <= res;
    end
  end

  `ASSERT_NEXT(a_prime_after_accept, clk, rst,
    blk_acc && r_sat != 5'd0, state == dcbc_pkg::ST_PRIME)
  `ASSERT_NEXT(a_wait_after_last, clk, rst,
    state == dcbc_pkg::ST_RUN && last_round, state == dcbc_pkg::ST_WAIT)
  `ASSERT_IMPLIES(a_idx_in_range, clk, rst,
    state == dcbc_pkg::ST_RUN, 5'(idx) < rounds)

endmodule
